[rtl/i2r_pkg.sv]
// Shared types, constants and numeral tables for the integer to Roman encoder.
// Used by i2r_ctrl, i2r_datapath and integer_to_roman_encoder_core; no dependencies.
package i2r_pkg;

	localparam int NUM_W      = 12;
	localparam int LETTER_W   = 7;
	localparam int DIG_W      = 4;
	localparam int POS_W      = 2;
	localparam int IDX_W      = 2;
	localparam int LEN_W      = 3;
	localparam int NUM_DIGITS = 4;
	localparam int WIDE_W     = NUM_W + 2;

	localparam logic [NUM_W-1:0] MAX_ROMAN = 12'd3999;

	localparam logic [WIDE_W-1:0] SCALE_TH = 14'd1000;
	localparam logic [WIDE_W-1:0] SCALE_HU = 14'd100;
	localparam logic [WIDE_W-1:0] SCALE_TE = 14'd10;

	localparam logic [POS_W-1:0] POS_TH = 2'd3;
	localparam logic [POS_W-1:0] POS_HU = 2'd2;
	localparam logic [POS_W-1:0] POS_TE = 2'd1;
	localparam logic [POS_W-1:0] POS_ON = 2'd0;

	localparam logic [LETTER_W-1:0] CH_M = 7'h4D;
	localparam logic [LETTER_W-1:0] CH_D = 7'h44;
	localparam logic [LETTER_W-1:0] CH_C = 7'h43;
	localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
	localparam logic [LETTER_W-1:0] CH_X = 7'h58;
	localparam logic [LETTER_W-1:0] CH_V = 7'h56;
	localparam logic [LETTER_W-1:0] CH_I = 7'h49;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SYM_ONE,
		SYM_FIVE,
		SYM_TEN
	} sym_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPLIT_TH,
		S_SPLIT_HU,
		S_SPLIT_TE,
		S_EMIT,
		S_FLAG
	} state_t;

	typedef struct packed {
		logic             load;
		logic             split;
		logic [POS_W-1:0] split_pos;
		logic             emit_step;
		logic             emit_flag;
	} cmd_t;

	typedef struct packed {
		logic is_zero;
		logic is_over;
		logic out_free;
		logic run_last;
	} sts_t;

	// decimal digit at a constant scale: count of thresholds k*scale that rem reaches
	function automatic logic [DIG_W-1:0] digit_of(logic [NUM_W-1:0] rem,
			logic [WIDE_W-1:0] scale);
		logic [DIG_W-1:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({2'b00, rem} >= WIDE_W'(WIDE_W'(k) * scale))
				d = DIG_W'(k);
		end
		return d;
	endfunction

	function automatic logic [NUM_W-1:0] rem_after(logic [NUM_W-1:0] rem,
			logic [DIG_W-1:0] d, logic [WIDE_W-1:0] scale);
		logic [WIDE_W-1:0] diff;
		diff = {2'b00, rem} - WIDE_W'({{(WIDE_W-DIG_W){1'b0}}, d} * scale);
		return diff[NUM_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] seq_len(logic [DIG_W-1:0] d);
		logic [LEN_W-1:0] n;
		unique case (d)
			4'd1, 4'd5:             n = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
			4'd3, 4'd7:             n = 3'd3;
			4'd8:                   n = 3'd4;
			default:                n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic sym_t sym_at(logic [DIG_W-1:0] d, logic [IDX_W-1:0] idx);
		sym_t s;
		priority if (d == 4'd9)
			s = (idx == '0) ? SYM_ONE : SYM_TEN;
		else if (d >= 4'd5)
			s = (idx == '0) ? SYM_FIVE : SYM_ONE;
		else if (d == 4'd4)
			s = (idx == '0) ? SYM_ONE : SYM_FIVE;
		else
			s = SYM_ONE;
		return s;
	endfunction

	function automatic logic [LETTER_W-1:0] letter_of(logic [POS_W-1:0] pos, sym_t s);
		logic [LETTER_W-1:0] c;
		unique case (pos)
			POS_TH: c = CH_M;
			POS_HU: c = (s == SYM_ONE) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
			POS_TE: c = (s == SYM_ONE) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
			default: c = (s == SYM_ONE) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
		endcase
		return c;
	endfunction

endpackage

[rtl/i2r_datapath.sv]
// Datapath: number register, decimal digit split, letter walk and output register.
// Depends on i2r_pkg; driven by i2r_ctrl through cmd_t, reports through sts_t.
module i2r_datapath import i2r_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [NUM_W-1:0]    number,
	output logic [LETTER_W-1:0] letter,
	output status_t             status,
	output logic                last,
	output logic                out_valid,
	input  logic                out_ready
);

	logic [NUM_W-1:0]    rem_q;
	logic [DIG_W-1:0]    dig_q [NUM_DIGITS];
	logic [POS_W-1:0]    pos_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	status_t             status_q;
	logic                last_q;

	logic [DIG_W-1:0]      d_split;
	logic [NUM_W-1:0]      rem_split;
	logic [DIG_W-1:0]      ones_new;
	logic [NUM_DIGITS-1:0] nz_init;
	logic [POS_W-1:0]      init_pos;

	logic [DIG_W-1:0]      cur_dig;
	logic [LETTER_W-1:0]   cur_letter;
	logic                  digit_done;
	logic [NUM_DIGITS-1:0] nz;
	logic                  has_lower;
	logic [POS_W-1:0]      next_pos;

	always_comb begin
		unique case (cmd.split_pos)
			POS_TH: begin
				d_split   = digit_of(rem_q, SCALE_TH);
				rem_split = rem_after(rem_q, d_split, SCALE_TH);
			end
			POS_HU: begin
				d_split   = digit_of(rem_q, SCALE_HU);
				rem_split = rem_after(rem_q, d_split, SCALE_HU);
			end
			default: begin
				d_split   = digit_of(rem_q, SCALE_TE);
				rem_split = rem_after(rem_q, d_split, SCALE_TE);
			end
		endcase
	end

	assign ones_new = rem_split[DIG_W-1:0];
	assign nz_init  = {dig_q[3] != '0, dig_q[2] != '0, d_split != '0, ones_new != '0};

	// first letter comes from the highest nonzero digit
	always_comb begin
		priority if (nz_init[3])
			init_pos = POS_TH;
		else if (nz_init[2])
			init_pos = POS_HU;
		else if (nz_init[1])
			init_pos = POS_TE;
		else
			init_pos = POS_ON;
	end

	assign cur_dig    = dig_q[pos_q];
	assign cur_letter = letter_of(pos_q, sym_at(cur_dig, idx_q));
	assign digit_done = (LEN_W'(idx_q) + 3'd1) == seq_len(cur_dig);

	always_comb begin
		has_lower = 1'b0;
		next_pos  = POS_ON;
		for (int j = 0; j < NUM_DIGITS; j++) begin
			nz[j] = dig_q[j] != '0;
			if ((POS_W'(j) < pos_q) && nz[j]) begin
				has_lower = 1'b1;
				next_pos  = POS_W'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			rem_q <= number;
		if (cmd.split) begin
			rem_q              <= rem_split;
			dig_q[cmd.split_pos] <= d_split;
			if (cmd.split_pos == POS_TE) begin
				dig_q[POS_ON] <= ones_new;
				pos_q         <= init_pos;
				idx_q         <= '0;
			end
		end
		if (cmd.emit_step) begin
			letter_q <= cur_letter;
			status_q <= ST_OK;
			last_q   <= digit_done && !has_lower;
			if (digit_done) begin
				pos_q <= next_pos;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
		if (cmd.emit_flag) begin
			letter_q <= '0;
			status_q <= (rem_q == '0) ? ST_EMPTY : ST_RANGE;
			last_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_step || cmd.emit_flag)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.is_zero  = rem_q == '0;
	assign sts.is_over  = rem_q > MAX_ROMAN;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.run_last = digit_done && !has_lower;

	assign letter    = letter_q;
	assign status    = status_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

endmodule

[rtl/i2r_ctrl.sv]
// Controller: sequences load, then either three digit split steps and the letter walk
// or the single flag result. Depends on i2r_pkg; drives i2r_datapath.
module i2r_ctrl import i2r_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_SPLIT_TH;
				end
			end
			S_SPLIT_TH: begin
				// zero and over-range inputs skip the split and give one flagged result
				if (sts.is_zero || sts.is_over) begin
					state_next = S_FLAG;
				end else begin
					cmd.split     = 1'b1;
					cmd.split_pos = POS_TH;
					state_next    = S_SPLIT_HU;
				end
			end
			S_SPLIT_HU: begin
				cmd.split     = 1'b1;
				cmd.split_pos = POS_HU;
				state_next    = S_SPLIT_TE;
			end
			S_SPLIT_TE: begin
				cmd.split     = 1'b1;
				cmd.split_pos = POS_TE;
				state_next    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.run_last)
						state_next = S_IDLE;
				end
			end
			S_FLAG: begin
				if (sts.out_free) begin
					cmd.emit_flag = 1'b1;
					state_next    = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

endmodule

[rtl/integer_to_roman_encoder_core.sv]
// Integer to Roman numeral encoder, one ASCII letter per output transaction.
// Each number passes the three-step digit split and the letter walk, or gives one flagged
// result for zero/over-range; the walk emits one letter per cycle while the output is free.
// A run is L = 1..15 letters; a new number is taken only once the run or flag is emitted.
// Reset: arst_n asynchronously returns the controller to idle and empties the output register.
// Depends on i2r_pkg, i2r_ctrl and i2r_datapath.
module integer_to_roman_encoder_core import i2r_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] number
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [6:0] letter
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	output logic        m_axis_tlast
);

	cmd_t                cmd;
	sts_t                sts;
	logic [LETTER_W-1:0] letter;
	status_t             status;

	i2r_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2r_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.number    (s_axis_tdata[NUM_W-1:0]),
		.letter    (letter),
		.status    (status),
		.last      (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {1'b0, letter};
	assign m_axis_tuser = status;

	// one number at a time: no new input right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while previous number still in work");

	a_flag_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("flagged result not single or letter nonzero");

	a_letter_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OK) |->
			(m_axis_tdata[6:0] == CH_M) || (m_axis_tdata[6:0] == CH_D) ||
			(m_axis_tdata[6:0] == CH_C) || (m_axis_tdata[6:0] == CH_L) ||
			(m_axis_tdata[6:0] == CH_X) || (m_axis_tdata[6:0] == CH_V) ||
			(m_axis_tdata[6:0] == CH_I))
		else $error("illegal numeral letter");

	a_walk_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> !s_axis_tready)
		else $error("letter walk while input side open");

endmodule

[tb/sv/integer_to_roman_encoder_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_roman_encoder_core: numbers in, numeral letters out.
// Predicts each letter run locally and compares every output transaction; needs i2r_pkg.
module integer_to_roman_encoder_core_tb;
	import i2r_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		logic [LETTER_W-1:0] letter;
		status_t             status;
		logic                last;
	} numeral_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [11:0] number
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [6:0] letter
	logic [1:0]  m_axis_tuser;  // [1:0] status
	logic        m_axis_tlast;

	numeral_item_t       numeral_q[$];
	logic [LETTER_W-1:0] run_buf[16];
	int                  run_len;

	bit idle_en;
	int hold_len;
	int hold_seq;
	int errors = 0;
	int cycle_count = 0;
	int n_items;
	int n_letters = 0;
	int n_empty;
	int n_range;

	integer_to_roman_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// one decimal digit: units, five plus units, or a subtractive pair
	function automatic void add_digit(int d, logic [LETTER_W-1:0] one,
			logic [LETTER_W-1:0] five, logic [LETTER_W-1:0] ten);
		if (d == 9) begin
			run_buf[run_len++] = one;
			run_buf[run_len++] = ten;
		end else if (d >= 5) begin
			run_buf[run_len++] = five;
			for (int j = 5; j < d; j++)
				run_buf[run_len++] = one;
		end else if (d == 4) begin
			run_buf[run_len++] = one;
			run_buf[run_len++] = five;
		end else begin
			for (int j = 0; j < d; j++)
				run_buf[run_len++] = one;
		end
	endfunction

	function automatic void predict_numeral(logic [NUM_W-1:0] number);
		int n;
		numeral_item_t it;
		n = number;
		if (n == 0 || n > 3999) begin
			it.letter = '0;
			it.status = (n == 0) ? ST_EMPTY : ST_RANGE;
			it.last   = 1'b1;
			numeral_q.push_back(it);
			if (n == 0)
				n_empty++;
			else
				n_range++;
		end else begin
			run_len = 0;
			for (int j = 0; j < n / 1000; j++)
				run_buf[run_len++] = CH_M;
			add_digit((n / 100) % 10, CH_C, CH_D, CH_M);
			add_digit((n / 10) % 10, CH_X, CH_L, CH_C);
			add_digit(n % 10, CH_I, CH_V, CH_X);
			for (int j = 0; j < run_len; j++) begin
				it.letter = run_buf[j];
				it.status = ST_OK;
				it.last   = (j == run_len - 1);
				numeral_q.push_back(it);
			end
		end
	endfunction

	// one input transaction, with an occasional gap in front of it
	task automatic send_number(input logic [NUM_W-1:0] number);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {4'h0, number};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		predict_numeral(number);
		n_items++;
	endtask

	task automatic sender_rest();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drain();
		while (numeral_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic [NUM_W-1:0] pick_number();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r <= 2)
			return NUM_W'($urandom_range(4000, 4095));
		else if (r == 3)
			return NUM_W'($urandom_range(0, 4095));
		return NUM_W'($urandom_range(1, 3999));
	endfunction

	task automatic test_directed();
		logic [NUM_W-1:0] vals[$] = '{0, 1, 3999, 4000, 4095, 3888, 4, 9, 5, 8, 40, 90,
			400, 900, 444, 999, 1994, 2024, 3, 6, 7, 1000, 500, 50, 10};
		idle_en = 1'b1;
		foreach (vals[i])
			send_number(vals[i]);
		sender_rest();
		wait_drain();
	endtask

	// receiver blocks for a long stretch while long runs keep coming
	task automatic test_hold_off();
		idle_en  = 1'b0;
		hold_len = 400;
		hold_seq++;
		for (int i = 0; i < 20; i++)
			send_number((i % 4 == 0) ? 12'd3888 : NUM_W'($urandom_range(3000, 3999)));
		sender_rest();
		wait_drain();
	endtask

	task automatic test_random_mixed();
		idle_en = 1'b1;
		for (int i = 0; i < 130; i++)
			send_number(pick_number());
		sender_rest();
		wait_drain();
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int i = 0; i < 40; i++)
			send_number(pick_number());
		sender_rest();
	endtask

	// receiver side: random stall bursts plus the requested long hold-off
	initial begin
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left    = 0;
		hold_left     = 0;
		hold_seen     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		numeral_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_letters++;
			if (numeral_q.size() == 0) begin
				$display("%0t: unexpected transaction, got tdata %h tuser %0d tlast %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = numeral_q.pop_front();
				if (m_axis_tdata !== {1'b0, want.letter} || m_axis_tuser !== want.status ||
						m_axis_tlast !== want.last) begin
					$display("%0t: mismatch, expected tdata %h tuser %0d tlast %b, got %h %0d %b",
						$time, {1'b0, want.letter}, want.status, want.last,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("integer_to_roman_encoder_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		idle_en       = 1'b0;
		hold_len      = 0;
		hold_seq      = 0;
		n_items       = 0;
		n_empty       = 0;
		n_range       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_hold_off();
		test_random_mixed();
		test_back_to_back();
		wait_drain();

		$display("%0d numbers sent (%0d zero, %0d over range), %0d output transactions checked",
			n_items, n_empty, n_range, n_letters);
		$display("covered extremes, subtractive digits, long hold-off and back-to-back traffic");
		if (errors == 0 && numeral_q.size() == 0)
			$display("integer_to_roman_encoder_core_tb: PASS");
		else
			$display("integer_to_roman_encoder_core_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/i2r_pkg.sv
rtl/i2r_datapath.sv
rtl/i2r_ctrl.sv
rtl/integer_to_roman_encoder_core.sv
tb/sv/integer_to_roman_encoder_core_tb.sv
